[sv/pqt_pkg.sv]
// ----------------------------------------------------------------------------
// pqt_pkg
// Shared types and constants for the prime quadruplet trial division block.
// ----------------------------------------------------------------------------
package pqt_pkg;

  // width of the numbers under test
  localparam int NUMBER_WIDTH = 16;
  // width of each result field on the ports
  localparam int FIELD_WIDTH  = 16;
  // width of the candidate port
  localparam int CAND_WIDTH   = 16;

  // members of a quadruplet and their offsets from n
  localparam int MEMBERS = 4;
  localparam logic [MEMBERS-1:0][3:0] MEMBER_OFFSET = {4'd8, 4'd6, 4'd2, 4'd0};

  // trial divisor never exceeds about the square root of the top member
  localparam int DIV_WIDTH  = NUMBER_WIDTH / 2 + 1;
  // running square of the divisor
  localparam int DSQ_WIDTH  = NUMBER_WIDTH + 2;

  // remainder unit retires this many dividend bits per cycle
  localparam int BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES     = (NUMBER_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int DVD_WIDTH      = DIV_CYCLES * BITS_PER_CYCLE;
  localparam int DIV_CNT_WIDTH  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // result status codes
  typedef enum logic [1:0] {
    STATUS_NOT_QUAD = 2'd0,
    STATUS_QUAD     = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  // classified candidate as it travels from front to back
  typedef struct packed {
    logic                                      out_of_range;
    logic [MEMBERS-1:0][NUMBER_WIDTH-1:0]      member;
  } entry_t;

endpackage

[sv/prime_quadruplet_test.sv]
// ----------------------------------------------------------------------------
// prime_quadruplet_test
// Checks whether n, n+2, n+6 and n+8 are all prime by trial division.
// ----------------------------------------------------------------------------
// A candidate is taken when start is high and busy is low; a front register
// and a two-word queue sit ahead of the divider, so busy only rises once
// three candidates wait behind the one in work. Each result appears for one
// cycle with done high and cannot be held off. A candidate below two or whose
// n+8 overflows is reported without division. Otherwise the four members
// are divided together by every divisor d from 2 upward; each divisor
// passes through the shift-subtract units in steps of eight remainder bits
// and then through a check state, and the loop ends at the first divisor
// that hits a member or once (d+1)*(d+1) passes n+8.
// ----------------------------------------------------------------------------
module prime_quadruplet_test (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pqt_pkg::CAND_WIDTH-1:0]  candidate,
  output logic                            busy,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [pqt_pkg::FIELD_WIDTH-1:0] first_member,
  output logic [pqt_pkg::FIELD_WIDTH-1:0] second_member,
  output logic [pqt_pkg::FIELD_WIDTH-1:0] third_member,
  output logic [pqt_pkg::FIELD_WIDTH-1:0] fourth_member
);
  import pqt_pkg::*;

  logic                                 push;
  entry_t                               push_entry;
  logic                                 queue_full;
  logic                                 queue_empty;
  entry_t                               head;
  logic                                 pop;
  status_t                              result_status;
  logic [MEMBERS-1:0][NUMBER_WIDTH-1:0] result_member;

  // front: accept and classify
  pqt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .candidate  (candidate),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .push_entry (push_entry)
  );

  // queue between front and back
  pqt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .empty      (queue_empty),
    .head       (head)
  );

  // back: trial division
  pqt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (queue_empty),
    .head          (head),
    .pop           (pop),
    .done          (done),
    .status        (result_status),
    .result_member (result_member)
  );

  // result fields
  assign status        = result_status;
  assign first_member  = FIELD_WIDTH'(result_member[0]);
  assign second_member = FIELD_WIDTH'(result_member[1]);
  assign third_member  = FIELD_WIDTH'(result_member[2]);
  assign fourth_member = FIELD_WIDTH'(result_member[3]);

endmodule

[sv/pqt_front.sv]
// ----------------------------------------------------------------------------
// pqt_front
// Accepts candidates, forms the four members and flags out-of-range ones.
// ----------------------------------------------------------------------------
module pqt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pqt_pkg::CAND_WIDTH-1:0] candidate,
  input  logic                           queue_full,
  output logic                           busy,
  output logic                           push,
  output pqt_pkg::entry_t                push_entry
);
  import pqt_pkg::*;

  logic                    hold_valid;
  entry_t                  hold;
  entry_t                  classified;
  logic [NUMBER_WIDTH-1:0] n;
  logic [NUMBER_WIDTH:0]   top_sum;
  logic                    accept;

  // handshake: hold stage frees up whenever the queue takes its word
  assign busy   = hold_valid && queue_full;
  assign accept = start && !busy;
  assign push   = hold_valid && !queue_full;
  assign push_entry = hold;

  // classify the candidate
  always_comb begin
    n       = NUMBER_WIDTH'(candidate);
    top_sum = {1'b0, n} + (NUMBER_WIDTH + 1)'(MEMBER_OFFSET[MEMBERS-1]);
    classified.out_of_range = (n < NUMBER_WIDTH'(2)) || top_sum[NUMBER_WIDTH];
    for (int k = 0; k < MEMBERS; k++) begin
      classified.member[k] = n + NUMBER_WIDTH'(MEMBER_OFFSET[k]);
    end
  end

  // hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
        hold       <= classified;
      end else if (push) begin
        hold_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/pqt_queue.sv]
// ----------------------------------------------------------------------------
// pqt_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module pqt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pqt_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output pqt_pkg::entry_t head
);
  import pqt_pkg::*;

  entry_t                mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/pqt_rem_unit.sv]
// ----------------------------------------------------------------------------
// pqt_rem_unit
// Shift-subtract remainder unit: member mod divisor, several bits per cycle.
// ----------------------------------------------------------------------------
module pqt_rem_unit (
  input  logic                             clk,
  input  logic                             load,
  input  logic                             step,
  input  logic [pqt_pkg::NUMBER_WIDTH-1:0] dividend,
  input  logic [pqt_pkg::DIV_WIDTH-1:0]    divisor,
  output logic [pqt_pkg::DIV_WIDTH-1:0]    rem
);
  import pqt_pkg::*;

  logic [DVD_WIDTH-1:0] dvd;
  logic [DVD_WIDTH-1:0] dvd_next;
  logic [DIV_WIDTH-1:0] rem_next;

  // one group of restoring steps, most significant bit first
  always_comb begin
    logic [DIV_WIDTH:0] t;
    rem_next = rem;
    dvd_next = dvd;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      t = {rem_next, dvd_next[DVD_WIDTH-1]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next = t[DIV_WIDTH-1:0];
      dvd_next = {dvd_next[DVD_WIDTH-2:0], 1'b0};
    end
  end

  // dividend shifter and partial remainder
  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= DVD_WIDTH'(dividend);
      rem <= '0;
    end else if (step) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

endmodule

[sv/pqt_back.sv]
// ----------------------------------------------------------------------------
// pqt_back
// Runs trial division over all four members at once and issues the result.
// ----------------------------------------------------------------------------
module pqt_back (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   empty,
  input  pqt_pkg::entry_t                                        head,
  output logic                                                   pop,
  output logic                                                   done,
  output pqt_pkg::status_t                                       status,
  output logic [pqt_pkg::MEMBERS-1:0][pqt_pkg::NUMBER_WIDTH-1:0] result_member
);
  import pqt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK
  } state_t;

  state_t                                state;
  entry_t                                cur;
  logic [DIV_WIDTH-1:0]                  d;
  logic [DSQ_WIDTH-1:0]                  d_sq;
  logic [DIV_CNT_WIDTH-1:0]              cnt;
  logic [MEMBERS-1:0][DIV_WIDTH-1:0]     rem;
  logic [DIV_WIDTH-1:0]                  d_next;
  logic [DSQ_WIDTH-1:0]                  d_sq_next;
  logic                                  composite;
  logic                                  bound_reached;
  logic                                  load;
  logic                                  step;

  // control toward the queue and the remainder units
  assign pop       = (state == ST_IDLE) && !empty;
  assign d_next    = d + 1'b1;
  assign d_sq_next = d_sq + DSQ_WIDTH'({d, 1'b1});
  assign bound_reached = d_sq_next > DSQ_WIDTH'(cur.member[MEMBERS-1]);
  assign load = (pop && !head.out_of_range) ||
                ((state == ST_CHECK) && !composite && !bound_reached);
  assign step = (state == ST_DIV);

  // a member is composite when a divisor within its bound leaves no remainder
  always_comb begin
    composite = 1'b0;
    for (int k = 0; k < MEMBERS; k++) begin
      if ((d_sq <= DSQ_WIDTH'(cur.member[k])) && (rem[k] == '0)) begin
        composite = 1'b1;
      end
    end
  end

  // one remainder unit per member
  for (genvar k = 0; k < MEMBERS; k++) begin : g_lane
    pqt_rem_unit u_rem (
      .clk      (clk),
      .load     (load),
      .step     (step),
      .dividend ((state == ST_IDLE) ? head.member[k] : cur.member[k]),
      .divisor  (d),
      .rem      (rem[k])
    );
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            cur <= head;
            if (head.out_of_range) begin
              done          <= 1'b1;
              status        <= STATUS_RANGE;
              // only the first member is reported, the others read zero
              result_member <= (MEMBERS * NUMBER_WIDTH)'(head.member[0]);
            end else begin
              d     <= DIV_WIDTH'(2);
              d_sq  <= DSQ_WIDTH'(4);
              cnt   <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_WIDTH'(DIV_CYCLES - 1)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (composite) begin
            done          <= 1'b1;
            status        <= STATUS_NOT_QUAD;
            result_member <= cur.member;
            state         <= ST_IDLE;
          end else if (bound_reached) begin
            done          <= 1'b1;
            status        <= STATUS_QUAD;
            result_member <= cur.member;
            state         <= ST_IDLE;
          end else begin
            d     <= d_next;
            d_sq  <= d_sq_next;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/prime_quadruplet_test_tb.sv]
// ----------------------------------------------------------------------------
// prime_quadruplet_test_tb
// Self-checking bench for the prime quadruplet trial division block.
// ----------------------------------------------------------------------------
// A driver feeds candidate words from a queue and a monitor predicts the
// verdict for each accepted word and checks it against the next done strobe.
// Stimulus is a few directed corner cases, then random candidates weighted
// toward real quadruplets and numbers of the form 30k+11, so that the
// divider runs deep, mixed with edge values and plain random words. The
// sender idles at different rates over three phases and at times waits until
// every verdict is back. A watchdog ends the run when nothing moves.
// ----------------------------------------------------------------------------
module prime_quadruplet_test_tb;
  import pqt_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 1148;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 1000;
  localparam int PRINT_LIMIT  = 50;

  // one queued candidate with its sender behavior
  typedef struct {
    logic [CAND_WIDTH-1:0] value;
    int unsigned           idle_pct;
    bit                    drain_first;
  } cand_word_t;

  // one predicted verdict
  typedef struct {
    logic [CAND_WIDTH-1:0]  cand;
    status_t                status;
    logic [FIELD_WIDTH-1:0] first;
    logic [FIELD_WIDTH-1:0] second;
    logic [FIELD_WIDTH-1:0] third;
    logic [FIELD_WIDTH-1:0] fourth;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [CAND_WIDTH-1:0]  candidate = '0;
  logic                   busy;
  logic                   done;
  logic [1:0]             status;
  logic [FIELD_WIDTH-1:0] first_member;
  logic [FIELD_WIDTH-1:0] second_member;
  logic [FIELD_WIDTH-1:0] third_member;
  logic [FIELD_WIDTH-1:0] fourth_member;

  cand_word_t  cand_queue[$];
  verdict_t    verdict_queue[$];
  int unsigned quad_list[$];
  int unsigned words_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count = 0;

  prime_quadruplet_test uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .candidate     (candidate),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .first_member  (first_member),
    .second_member (second_member),
    .third_member  (third_member),
    .fourth_member (fourth_member)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // trial division primality
  function automatic bit is_prime_num(longint unsigned m);
    longint unsigned d;
    if (m < 2) return 1'b0;
    for (d = 2; d * d <= m; d++) begin
      if (m % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // verdict for one candidate word
  function automatic verdict_t quad_verdict(logic [CAND_WIDTH-1:0] cand);
    verdict_t        v;
    longint unsigned lim;
    longint unsigned n;
    longint unsigned m2;
    longint unsigned m3;
    longint unsigned m4;
    lim = (64'd1 << NUMBER_WIDTH) - 1;
    n = longint'(cand) & lim;
    m2 = n + 2;
    m3 = n + 6;
    m4 = n + 8;
    v.cand = cand;
    v.first = n[FIELD_WIDTH-1:0];
    if (n < 2 || m4 > lim) begin
      v.status = STATUS_RANGE;
      v.second = '0;
      v.third = '0;
      v.fourth = '0;
    end else begin
      v.status = (is_prime_num(n) && is_prime_num(m2) && is_prime_num(m3) &&
                  is_prime_num(m4)) ? STATUS_QUAD : STATUS_NOT_QUAD;
      v.second = m2[FIELD_WIDTH-1:0];
      v.third = m3[FIELD_WIDTH-1:0];
      v.fourth = m4[FIELD_WIDTH-1:0];
    end
    return v;
  endfunction

  // one line per mismatch up to PRINT_LIMIT, all counted
  task automatic report_mismatch(string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic void push_word(int unsigned value, int unsigned idle_pct,
                                    bit drain_first);
    cand_word_t w;
    w.value = value[CAND_WIDTH-1:0];
    w.idle_pct = idle_pct;
    w.drain_first = drain_first;
    cand_queue.push_back(w);
  endfunction

  // random candidate, weighted toward long divider runs
  function automatic int unsigned random_cand();
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(99);
    top = (1 << CAND_WIDTH) - 1;
    if (pick < 20 && quad_list.size() > 0)
      return quad_list[$urandom_range(quad_list.size() - 1)];
    if (pick < 60)
      return 30 * $urandom_range((top - 19) / 30) + 11;
    if (pick < 65)
      return $urandom_range(12);
    if (pick < 70)
      return top - $urandom_range(12);
    return $urandom_range(top);
  endfunction

  // driver: present queued words, hold while busy
  always @(posedge clk) begin : driver
    cand_word_t head;
    if (rst) begin
      start <= 1'b0;
      candidate <= '0;
    end else begin
      if (start && !busy) words_sent <= words_sent + 1;
      if (start && busy) begin
        // hold the current word
      end else if (cand_queue.size() == 0) begin
        start <= 1'b0;
      end else begin
        head = cand_queue[0];
        if (head.drain_first) begin
          if (start || words_sent != verdicts_seen) begin
            start <= 1'b0;
          end else begin
            start <= 1'b1;
            candidate <= head.value;
            void'(cand_queue.pop_front());
          end
        end else if ($urandom_range(99) < head.idle_pct) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          candidate <= head.value;
          void'(cand_queue.pop_front());
        end
      end
    end
  end

  // monitor: check each done strobe, predict each accepted word
  always @(posedge clk) begin : monitor
    verdict_t want;
    if (!rst) begin
      if (done) begin
        verdicts_seen <= verdicts_seen + 1;
        if (verdict_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result, first_member %0d", first_member));
        end else begin
          want = verdict_queue.pop_front();
          if (status != want.status)
            report_mismatch($sformatf("cand %0d status got %0d want %0d",
                                      want.cand, status, want.status));
          if (first_member != want.first)
            report_mismatch($sformatf("cand %0d first_member got %0d want %0d",
                                      want.cand, first_member, want.first));
          if (second_member != want.second)
            report_mismatch($sformatf("cand %0d second_member got %0d want %0d",
                                      want.cand, second_member, want.second));
          if (third_member != want.third)
            report_mismatch($sformatf("cand %0d third_member got %0d want %0d",
                                      want.cand, third_member, want.third));
          if (fourth_member != want.fourth)
            report_mismatch($sformatf("cand %0d fourth_member got %0d want %0d",
                                      want.cand, fourth_member, want.fourth));
        end
      end
      if (start && !busy) verdict_queue.push_back(quad_verdict(candidate));

      // watchdog on cycles with no word moving either way
      if (done || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : sequencer
    int unsigned directed[$];
    int unsigned phase_len;
    int unsigned idle_pct;
    bit          drain;
    verdict_t    probe;

    // every quadruplet that fits in the candidate range
    for (int k = 0; k < (1 << CAND_WIDTH); k++) begin
      probe = quad_verdict(k[CAND_WIDTH-1:0]);
      if (probe.status == STATUS_QUAD) quad_list.push_back(k);
    end

    // directed corners: below two, small primes, known quadruplets,
    // top member at the limit and just past it, bit patterns
    directed = '{0, 1, 2, 3, 4, 5, 7, 9, 11, 13, 25, 101, 191, 1481,
                 65519, 65521, 65527, 65528, 65529, 65535, 32768,
                 16'h5555, 16'hAAAA};
    foreach (directed[i]) push_word(directed[i], 14, 1'b0);

    // three random phases with different sender idling
    phase_len = RANDOM_WORDS / 3;
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 14 : (p == 1) ? 64 : 0;
      for (int i = 0; i < phase_len; i++) begin
        drain = (i == 0) || (p == 2 && i == phase_len / 2);
        push_word(random_cand(), idle_pct, drain);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (cand_queue.size() != 0 || start || verdict_queue.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pqt_pkg.sv
sv/pqt_front.sv
sv/pqt_queue.sv
sv/pqt_rem_unit.sv
sv/pqt_back.sv
sv/prime_quadruplet_test.sv
tb/prime_quadruplet_test_tb.sv
